FILE: src/tbm_pkg.sv
// Shared constants, codes and control structs of the telemetry bit modulator.
// Depends on nothing; every other file refers to it by scoped names.
package tbm_pkg;

  // Sizes of the packet store, the shaping filter and the line-coded word.
  localparam int PACKET_WORDS = 96;
  localparam int SHAPE_TAPS   = 96;
  localparam int WORD_BITS    = 10;

  // The packet store holds one more word than the packet.
  localparam int PKT_DEPTH = PACKET_WORDS + 1;
  localparam int PTR_W     = $clog2(PKT_DEPTH);
  localparam int TAP_CNT_W = $clog2(SHAPE_TAPS + 1);

  // Field widths of the channels.
  localparam int IDX_W      = 7;
  localparam int VAL_W      = 18;
  localparam int COEF_W     = 18;
  localparam int SMP_W      = 16;
  localparam int SPB_W      = 12;
  localparam int BIW_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Filter arithmetic: Q1.17 by Q1.15 products summed in Q2.32 and wider.
  localparam int PROD_W      = COEF_W + SMP_W;
  localparam int ACC_W       = PROD_W + $clog2(SHAPE_TAPS) + 1;
  localparam int ROUND_SHIFT = 17;
  localparam int ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);
  localparam int SMP_MAX     = (2 ** (SMP_W - 1)) - 1;
  localparam int SMP_MIN     = -(2 ** (SMP_W - 1));

  // Sync word sent after reset or a restart.
  localparam logic [WORD_BITS-1:0] SYNC_WORD = 10'h0fa;

  // Reset values of the configuration registers.
  localparam logic [SPB_W-1:0]        SPB_RESET  = 12'd60;
  localparam logic signed [SMP_W-1:0] ONE_RESET  = 16'sh4000;
  localparam logic signed [SMP_W-1:0] ZERO_RESET = -16'sh4000;

  // Request codes.
  typedef enum logic [1:0] {
    ACT_PKT_WR  = 2'd0,
    ACT_COEF_WR = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_RESTART = 2'd3
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPB    = 3'd0,
    REG_TOGGLE = 3'd1,
    REG_SHAPE  = 3'd2,
    REG_ONE    = 3'd3,
    REG_ZERO   = 3'd4
  } cfg_reg_e;

  // Control of one filter cell.
  typedef struct packed {
    logic shift;
    logic rotate;
    logic coef_we;
  } cell_ctrl_t;

  // Requests to the bit serializer.
  typedef struct packed {
    logic tick;
    logic restart;
    logic pkt_we;
  } ser_req_t;

endpackage

FILE: src/tbm_if.sv
// Valid/ready channel interfaces of the telemetry bit modulator.
// Depends on tbm_pkg for the field widths.

// Request channel: one request per accepted item.
interface tbm_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          action;
  logic [tbm_pkg::IDX_W-1:0]           index;
  logic signed [tbm_pkg::VAL_W-1:0]    value;

  modport source (output valid, action, index, value, input ready);
  modport sink   (input valid, action, index, value, output ready);
endinterface

// Result channel: one result per request.
interface tbm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tbm_pkg::SMP_W-1:0]    sample;
  logic                                bit_sent;
  logic                                is_sample;

  modport source (output valid, sample, bit_sent, is_sample, input ready);
  modport sink   (input valid, sample, bit_sent, is_sample, output ready);
endinterface

// Configuration write channel.
interface tbm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tbm_pkg::CFG_IDX_W-1:0]       index;
  logic [tbm_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/tbm_cell.sv
// One cell of the shaping filter ring: a delay tap and its coefficient.
// Depends on tbm_pkg for widths and the cell control struct.
module tbm_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tbm_pkg::cell_ctrl_t                 ctrl_i,
  input  logic                                sel_i,
  input  logic signed [tbm_pkg::COEF_W-1:0]   coef_i,
  input  logic signed [tbm_pkg::SMP_W-1:0]    shift_d_i,
  input  logic signed [tbm_pkg::SMP_W-1:0]    rot_d_i,
  input  logic signed [tbm_pkg::COEF_W-1:0]   rot_c_i,
  output logic signed [tbm_pkg::SMP_W-1:0]    d_o,
  output logic signed [tbm_pkg::COEF_W-1:0]   c_o
);

  logic signed [tbm_pkg::SMP_W-1:0]  d_q, d_d;
  logic signed [tbm_pkg::COEF_W-1:0] c_q, c_d;

  // The tap either takes the newer neighbor's level on a shift, or rotates
  // one place toward the head of the ring during accumulation.
  always_comb begin
    d_d = d_q;
    if (ctrl_i.shift) begin
      d_d = shift_d_i;
    end else if (ctrl_i.rotate) begin
      d_d = rot_d_i;
    end
  end

  // The coefficient rotates along with the tap, and is loaded when selected.
  always_comb begin
    c_d = c_q;
    if (ctrl_i.rotate) begin
      c_d = rot_c_i;
    end else if (ctrl_i.coef_we && sel_i) begin
      c_d = coef_i;
    end
  end

  // The delay tap starts out cleared.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q <= '0;
    end else begin
      d_q <= d_d;
    end
  end

  // Coefficients hold no meaning until they are written.
  always_ff @(posedge clk_i) begin
    c_q <= c_d;
  end

  assign d_o = d_q;
  assign c_o = c_q;

endmodule

FILE: src/tbm_fir.sv
// Shaping filter: a ring of tap cells rotated past one multiply-accumulate.
// Depends on tbm_pkg and tbm_cell.
module tbm_fir (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [tbm_pkg::SMP_W-1:0]    level_i,
  input  logic                                coef_we_i,
  input  logic [tbm_pkg::IDX_W-1:0]           coef_idx_i,
  input  logic signed [tbm_pkg::COEF_W-1:0]   coef_i,
  output logic                                done_o,
  output logic signed [tbm_pkg::SMP_W-1:0]    sample_o
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_MAC,
    F_DRAIN,
    F_ROUND
  } fir_state_e;

  fir_state_e                                 state_q;
  logic [tbm_pkg::TAP_CNT_W-1:0]              cnt_q;
  logic signed [tbm_pkg::PROD_W-1:0]          prod_q;
  logic                                       prod_vld_q;
  logic signed [tbm_pkg::ACC_W-1:0]           acc_q;
  logic                                       done_q;
  logic signed [tbm_pkg::SMP_W-1:0]           sample_q;

  tbm_pkg::cell_ctrl_t                        ctrl;
  logic signed [tbm_pkg::SMP_W-1:0]           tap_d [tbm_pkg::SHAPE_TAPS];
  logic signed [tbm_pkg::COEF_W-1:0]          tap_c [tbm_pkg::SHAPE_TAPS];
  logic signed [tbm_pkg::PROD_W-1:0]          prod_w;
  logic signed [tbm_pkg::ACC_W:0]             rnd_w;
  logic signed [tbm_pkg::ACC_W:0]             quo_w;
  logic signed [tbm_pkg::SMP_W-1:0]           sat_w;

  // Cells shift a new level in on start, rotate while accumulating and
  // take coefficient writes only while the ring sits in its home position.
  always_comb begin
    ctrl.shift   = (state_q == F_IDLE) && start_i;
    ctrl.rotate  = (state_q == F_MAC);
    ctrl.coef_we = (state_q == F_IDLE) && coef_we_i;
  end

  // Cell 0 holds the newest level and sits at the head of the ring.
  for (genvar k = 0; k < tbm_pkg::SHAPE_TAPS; k++) begin : g_cell
    localparam int NXT = (k + 1) % tbm_pkg::SHAPE_TAPS;
    localparam int PRV = (k == 0) ? 0 : k - 1;

    logic signed [tbm_pkg::SMP_W-1:0] shift_in;

    assign shift_in = (k == 0) ? level_i : tap_d[PRV];

    tbm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .sel_i     (coef_idx_i == tbm_pkg::IDX_W'(k)),
      .coef_i    (coef_i),
      .shift_d_i (shift_in),
      .rot_d_i   (tap_d[NXT]),
      .rot_c_i   (tap_c[NXT]),
      .d_o       (tap_d[k]),
      .c_o       (tap_c[k])
    );
  end

  // Product of the pair at the head of the ring.
  assign prod_w = tap_c[0] * tap_d[0];

  // Round half up by adding half an LSB and flooring, then saturate.
  always_comb begin
    rnd_w = {acc_q[tbm_pkg::ACC_W-1], acc_q} + (tbm_pkg::ACC_W + 1)'(tbm_pkg::ROUND_BIAS);
    quo_w = rnd_w >>> tbm_pkg::ROUND_SHIFT;
    if (quo_w > (tbm_pkg::ACC_W + 1)'(tbm_pkg::SMP_MAX)) begin
      sat_w = tbm_pkg::SMP_W'(tbm_pkg::SMP_MAX);
    end else if (quo_w < (tbm_pkg::ACC_W + 1)'(tbm_pkg::SMP_MIN)) begin
      sat_w = tbm_pkg::SMP_W'(tbm_pkg::SMP_MIN);
    end else begin
      sat_w = quo_w[tbm_pkg::SMP_W-1:0];
    end
  end

  // Sequencer: one tap product per cycle, registered ahead of the accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      cnt_q      <= '0;
      prod_q     <= '0;
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
      done_q     <= 1'b0;
      sample_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            acc_q      <= '0;
            prod_vld_q <= 1'b0;
            cnt_q      <= '0;
            state_q    <= F_MAC;
          end
        end
        F_MAC: begin
          prod_q     <= prod_w;
          prod_vld_q <= 1'b1;
          if (prod_vld_q) begin
            acc_q <= acc_q + tbm_pkg::ACC_W'(prod_q);
          end
          if (cnt_q == tbm_pkg::TAP_CNT_W'(tbm_pkg::SHAPE_TAPS - 1)) begin
            state_q <= F_DRAIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        F_DRAIN: begin
          acc_q      <= acc_q + tbm_pkg::ACC_W'(prod_q);
          prod_vld_q <= 1'b0;
          state_q    <= F_ROUND;
        end
        F_ROUND: begin
          sample_q <= sat_w;
          done_q   <= 1'b1;
          state_q  <= F_IDLE;
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign sample_o = sample_q;

endmodule

FILE: src/tbm_ser.sv
// Bit serializer: bit timing counters, word pointer and the packet store.
// Depends on tbm_pkg for widths, the sync word and the request struct.
module tbm_ser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tbm_pkg::ser_req_t                   req_i,
  input  logic [tbm_pkg::IDX_W-1:0]           idx_i,
  input  logic [tbm_pkg::WORD_BITS-1:0]       word_i,
  input  logic [tbm_pkg::SPB_W-1:0]           spb_i,
  input  logic                                toggle_i,
  output logic                                held_bit_o
);

  logic [tbm_pkg::WORD_BITS-1:0]  pkt_mem_q [tbm_pkg::PKT_DEPTH];
  logic [tbm_pkg::WORD_BITS-1:0]  rd_q;

  logic [tbm_pkg::SPB_W-1:0]      cnt_q, cnt_d;
  logic [tbm_pkg::BIW_W-1:0]      biw_q;
  logic [tbm_pkg::PTR_W-1:0]      wp_q;
  logic                           at_start_q;
  logic                           held_q;
  logic                           pend_q;
  logic [tbm_pkg::BIW_W-1:0]      pos_q;
  logic                           sync_q;

  logic                           new_bit;
  logic                           fetch;
  logic [tbm_pkg::BIW_W-1:0]      biw_w;
  logic [tbm_pkg::PTR_W-1:0]      wp_w;
  logic [tbm_pkg::PTR_W:0]        wp_inc;
  logic                           at_start_w;
  logic [tbm_pkg::WORD_BITS-1:0]  word_w;

  // A bit period ends at the start of a transmission or once the count
  // reaches the configured period.
  always_comb begin
    new_bit = ((cnt_q == '0) && (biw_q == '0) && (wp_q == '0)) || (cnt_q >= spb_i);
    fetch   = req_i.tick && new_bit && !toggle_i;
    cnt_d   = new_bit ? tbm_pkg::SPB_W'(1) : cnt_q + 1'b1;
  end

  // Advance to the next word once all of its bits are out; the first word
  // after a start is the sync word, and the pointer wraps back to entry 0.
  always_comb begin
    biw_w      = biw_q;
    wp_w       = wp_q;
    at_start_w = at_start_q;
    wp_inc     = {1'b0, wp_q} + 1'b1;
    if (biw_q >= tbm_pkg::BIW_W'(tbm_pkg::WORD_BITS)) begin
      biw_w = '0;
      if (at_start_q) begin
        at_start_w = 1'b0;
      end else if (wp_inc >= (tbm_pkg::PTR_W + 1)'(tbm_pkg::PKT_DEPTH)) begin
        wp_w = '0;
      end else begin
        wp_w = wp_inc[tbm_pkg::PTR_W-1:0];
      end
    end
  end

  // Word that supplies the bit fetched in the previous cycle.
  assign word_w = sync_q ? tbm_pkg::SYNC_WORD : rd_q;

  // Packet store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.pkt_we && (idx_i <= tbm_pkg::IDX_W'(tbm_pkg::PACKET_WORDS))) begin
      pkt_mem_q[idx_i[tbm_pkg::PTR_W-1:0]] <= word_i;
    end
    if (fetch) begin
      rd_q <= pkt_mem_q[wp_w];
    end
  end

  // Counters, pointer and the bit held on the line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      biw_q      <= '0;
      wp_q       <= '0;
      at_start_q <= 1'b1;
      held_q     <= 1'b0;
      pend_q     <= 1'b0;
      pos_q      <= '0;
      sync_q     <= 1'b0;
    end else begin
      if (pend_q) begin
        held_q <= word_w[pos_q];
        pend_q <= 1'b0;
      end
      if (req_i.restart) begin
        cnt_q      <= '0;
        biw_q      <= '0;
        wp_q       <= '0;
        at_start_q <= 1'b1;
      end else if (req_i.tick) begin
        cnt_q <= cnt_d;
        if (new_bit && toggle_i) begin
          held_q <= ~held_q;
        end else if (fetch) begin
          biw_q      <= biw_w + 1'b1;
          wp_q       <= wp_w;
          at_start_q <= at_start_w;
          pos_q      <= tbm_pkg::BIW_W'(tbm_pkg::WORD_BITS - 1) - biw_w;
          sync_q     <= at_start_w;
          pend_q     <= 1'b1;
        end
      end
    end
  end

  assign held_bit_o = held_q;

endmodule

FILE: src/telemetry_bit_modulator.sv
// Top level of the telemetry bit modulator: configuration, request
// sequencing and the result register. Depends on tbm_pkg, tbm_if, tbm_ser
// and tbm_fir.
//
//   channel  dir  handshake        payload
//   in_i     in   valid / ready    action, index, value
//   out_o    out  valid / ready    sample, bit_sent, is_sample
//   cfg_i    in   valid / ready    index, data (always ready)
//
// A sample tick runs the bit, level, filter (with shaping on) and result
// steps, one filter tap per cycle through the single multiply-accumulate;
// store writes and restarts run only the result step. The result register
// lets the next request in while a result waits; a held result stalls only
// the completion of the following request. Reset clears the delay line and
// counters and presets the configuration; the stores start undefined.
module telemetry_bit_modulator (
  input  logic   clk_i,
  input  logic   rst_ni,
  tbm_in_if.sink    in_i,
  tbm_out_if.source out_o,
  tbm_cfg_if.sink   cfg_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT,
    S_LEVEL,
    S_SHAPE,
    S_OUT
  } top_state_e;

  // Configuration registers.
  logic [tbm_pkg::SPB_W-1:0]         spb_q;
  logic                              toggle_q;
  logic                              shape_q;
  logic signed [tbm_pkg::SMP_W-1:0]  one_q;
  logic signed [tbm_pkg::SMP_W-1:0]  zero_q;

  top_state_e                        state_q;
  logic signed [tbm_pkg::SMP_W-1:0]  res_sample_q;
  logic                              res_is_q;
  logic                              out_vld_q;
  logic signed [tbm_pkg::SMP_W-1:0]  out_sample_q;
  logic                              out_bit_q;
  logic                              out_is_q;

  logic                              in_acc;
  tbm_pkg::action_e                  act;
  tbm_pkg::ser_req_t                 ser_req;
  logic                              held_bit;
  logic signed [tbm_pkg::SMP_W-1:0]  level;
  logic                              fir_start;
  logic                              fir_done;
  logic signed [tbm_pkg::SMP_W-1:0]  fir_sample;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign act         = tbm_pkg::action_e'(in_i.action);

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spb_q    <= tbm_pkg::SPB_RESET;
      toggle_q <= 1'b0;
      shape_q  <= 1'b1;
      one_q    <= tbm_pkg::ONE_RESET;
      zero_q   <= tbm_pkg::ZERO_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (tbm_pkg::cfg_reg_e'(cfg_i.index))
        tbm_pkg::REG_SPB:    spb_q    <= cfg_i.data[tbm_pkg::SPB_W-1:0];
        tbm_pkg::REG_TOGGLE: toggle_q <= cfg_i.data[0];
        tbm_pkg::REG_SHAPE:  shape_q  <= cfg_i.data[0];
        tbm_pkg::REG_ONE:    one_q    <= cfg_i.data;
        tbm_pkg::REG_ZERO:   zero_q   <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // Requests handed to the serializer on acceptance.
  always_comb begin
    ser_req.tick    = in_acc && (act == tbm_pkg::ACT_TICK);
    ser_req.restart = in_acc && (act == tbm_pkg::ACT_RESTART);
    ser_req.pkt_we  = in_acc && (act == tbm_pkg::ACT_PKT_WR);
  end

  tbm_ser u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (ser_req),
    .idx_i      (in_i.index),
    .word_i     (in_i.value[tbm_pkg::WORD_BITS-1:0]),
    .spb_i      (spb_q),
    .toggle_i   (toggle_q),
    .held_bit_o (held_bit)
  );

  // Line level of the held bit, shaped when the filter is on.
  assign level     = held_bit ? one_q : zero_q;
  assign fir_start = (state_q == S_LEVEL) && shape_q;

  tbm_fir u_fir (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (fir_start),
    .level_i    (level),
    .coef_we_i  (in_acc && (act == tbm_pkg::ACT_COEF_WR)),
    .coef_idx_i (in_i.index),
    .coef_i     (in_i.value),
    .done_o     (fir_done),
    .sample_o   (fir_sample)
  );

  // Request sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_sample_q <= '0;
      res_is_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      out_sample_q <= '0;
      out_bit_q    <= 1'b0;
      out_is_q     <= 1'b0;
    end else begin
      // A taken result empties the register unless a new one moves in.
      if (out_vld_q && out_o.ready && (state_q != S_OUT)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (act == tbm_pkg::ACT_TICK) begin
              res_is_q <= 1'b1;
              state_q  <= S_BIT;
            end else begin
              res_sample_q <= '0;
              res_is_q     <= 1'b0;
              state_q      <= S_OUT;
            end
          end
        end
        S_BIT: begin
          // The serializer settles the new bit in this cycle.
          state_q <= S_LEVEL;
        end
        S_LEVEL: begin
          if (shape_q) begin
            state_q <= S_SHAPE;
          end else begin
            res_sample_q <= level;
            state_q      <= S_OUT;
          end
        end
        S_SHAPE: begin
          if (fir_done) begin
            res_sample_q <= fir_sample;
            state_q      <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_vld_q || out_o.ready) begin
            out_vld_q    <= 1'b1;
            out_sample_q <= res_sample_q;
            out_bit_q    <= held_bit;
            out_is_q     <= res_is_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.sample    = out_sample_q;
  assign out_o.bit_sent  = out_bit_q;
  assign out_o.is_sample = out_is_q;

endmodule
